>>> hw/rtl/wtpe_pkg.sv
// Package for the whitespace-trim percent encoder: beat types, bundle type,
// escape table and hex digit helpers. No dependencies.
`default_nettype none

package wtpe_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MAX_OUT  = 6;
    localparam int unsigned CNT_W    = 3;

    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_TWO     = 8'h32;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_text;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              last;
    } code_t;

    // Up to six result bytes of one item, slot 0 goes out first.
    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               cnt;
        logic                           has_byte;
        logic                           last;
    } bundle_t;

    typedef struct packed {
        logic space_pending;
        logic content_seen;
    } trim_state_t;

    function automatic logic needs_escape(input logic [BYTE_W-1:0] c);
        logic hit;
        begin
            unique case (c)
                8'h22, 8'h27, 8'h5C, 8'h2F, 8'h3E, 8'h3C, 8'h20, 8'h25,
                8'h7B, 8'h7D, 8'h7C, 8'h5E, 8'h60, 8'h3A, 8'h3F, 8'h23,
                8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, 8'h26, 8'h28, 8'h29,
                8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: hit = 1'b1;
                default:                            hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    // Uppercase ASCII hex digit of a nibble.
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] d;
        begin
            if (nib < 4'd10)
                d = 8'h30 + {4'd0, nib};
            else
                d = 8'h37 + {4'd0, nib};
            return d;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wtpe_enc.sv
// Combinational trim and escape step for one item: builds the result bundle
// and the next trim state. Depends on wtpe_pkg.
`default_nettype none

module wtpe_enc (
    input  wire wtpe_pkg::item_t       item,
    input  wire wtpe_pkg::trim_state_t st,
    output wtpe_pkg::bundle_t          bundle,
    output wtpe_pkg::trim_state_t      st_next
);

    logic [wtpe_pkg::BYTE_W-1:0] b;
    logic                        emit_sp;
    logic                        emit_b;
    logic                        esc;
    logic [wtpe_pkg::CNT_W-1:0]  cnt;

    always_comb
    begin
        b       = (item.in_byte == wtpe_pkg::CH_TAB) ? wtpe_pkg::CH_SPACE : item.in_byte;
        esc     = wtpe_pkg::needs_escape(b);
        emit_sp = 1'b0;
        emit_b  = 1'b0;
        st_next = st;

        if (b == wtpe_pkg::CH_LF)
        begin
            // line feed dropped
        end
        else if (b == wtpe_pkg::CH_SPACE)
        begin
            st_next.space_pending = st.space_pending | st.content_seen;
        end
        else
        begin
            emit_sp = st.space_pending && (b != wtpe_pkg::CH_LT) && (b != wtpe_pkg::CH_GT);
            emit_b  = 1'b1;
            st_next.space_pending = 1'b0;
            st_next.content_seen  = 1'b1;
        end

        if (item.end_of_text)
        begin
            st_next.space_pending = 1'b0;
            st_next.content_seen  = 1'b0;
        end
    end

    always_comb
    begin
        bundle.bytes = '0;
        cnt          = '0;

        if (emit_sp)
        begin
            bundle.bytes[0] = wtpe_pkg::CH_PERCENT;
            bundle.bytes[1] = wtpe_pkg::CH_TWO;
            bundle.bytes[2] = wtpe_pkg::CH_ZERO;
            cnt             = 3'd3;
        end

        if (emit_b)
        begin
            if (esc)
            begin
                if (emit_sp)
                begin
                    bundle.bytes[3] = wtpe_pkg::CH_PERCENT;
                    bundle.bytes[4] = wtpe_pkg::hex_digit(b[7:4]);
                    bundle.bytes[5] = wtpe_pkg::hex_digit(b[3:0]);
                end
                else
                begin
                    bundle.bytes[0] = wtpe_pkg::CH_PERCENT;
                    bundle.bytes[1] = wtpe_pkg::hex_digit(b[7:4]);
                    bundle.bytes[2] = wtpe_pkg::hex_digit(b[3:0]);
                end
                cnt = cnt + 3'd3;
            end
            else
            begin
                if (emit_sp)
                    bundle.bytes[3] = b;
                else
                    bundle.bytes[0] = b;
                cnt = cnt + 3'd1;
            end
        end

        // empty end marker: one result without data
        bundle.has_byte = (cnt != '0);
        if (item.end_of_text && (cnt == '0))
            bundle.cnt = 3'd1;
        else
            bundle.cnt = cnt;
        bundle.last = item.end_of_text;
    end

endmodule

`default_nettype wire

>>> hw/rtl/whitespace_trim_percent_encoder_core.sv
// Top level of the whitespace-trim percent encoder: input register, trim
// state, result bundle register and byte serializer. Depends on wtpe_pkg, wtpe_enc.
`default_nettype none

// Takes one text byte per beat (end_of_text marks the final byte of a text)
// and gives one encoded byte per beat. Tabs turn into spaces, line feeds are
// dropped, leading spaces and space runs are trimmed, a held space is dropped
// before '<', '>' and at the end of the text, and reserved characters leave
// as '%' plus two uppercase hex digits. An end beat that yields nothing gives
// one result with has_byte low and last high. The output side moves one
// byte per cycle while code_stall is low. An item yields 1 result byte when
// plain, 3 when escaped and up to 6 with a released space; an item with no
// result still passes through the input register. An accepted item passes
// through the input register and the result bundle register before its
// first result shows. The next item is taken while the current bundle drains.
module whitespace_trim_percent_encoder_core (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    output logic                   item_stall,
    input  wire wtpe_pkg::item_t   item_data,
    output logic                   code_valid,
    input  wire                    code_stall,
    output wtpe_pkg::code_t        code_data
);

    // input register
    logic                  in_valid_reg;
    wtpe_pkg::item_t       in_item_reg;

    // trim state, touched only when an item moves into the bundle stage
    wtpe_pkg::trim_state_t st_reg;
    wtpe_pkg::trim_state_t st_next;

    // result bundle: bytes shift toward slot 0 as beats leave
    logic [wtpe_pkg::MAX_OUT-1:0][wtpe_pkg::BYTE_W-1:0] bytes_reg;
    logic [wtpe_pkg::MAX_OUT-1:0][wtpe_pkg::BYTE_W-1:0] bytes_next;
    logic [wtpe_pkg::CNT_W-1:0] cnt_reg;
    logic [wtpe_pkg::CNT_W-1:0] cnt_next;
    logic                       has_reg;
    logic                       last_reg;

    wtpe_pkg::bundle_t     bundle;

    logic item_take;
    logic code_take;
    logic bundle_done;
    logic bundle_free;
    logic move;

    wtpe_enc u_enc (
        .item    (in_item_reg),
        .st      (st_reg),
        .bundle  (bundle),
        .st_next (st_next)
    );

    assign code_valid  = (cnt_reg != '0);
    assign code_take   = code_valid && !code_stall;
    assign bundle_done = code_take && (cnt_reg == 3'd1);
    assign bundle_free = !code_valid || bundle_done;
    assign move        = in_valid_reg && bundle_free;

    // stall only while an item sits in the input register and cannot move on
    assign item_stall  = in_valid_reg && !bundle_free;
    assign item_take   = item_valid && !item_stall;

    assign code_data.out_byte = bytes_reg[0];
    assign code_data.has_byte = has_reg;
    assign code_data.last     = last_reg && (cnt_reg == 3'd1);

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (move)
        begin
            bytes_next = bundle.bytes;
            cnt_next   = bundle.cnt;
        end
        else if (code_take)
        begin
            for (int i = 0; i < wtpe_pkg::MAX_OUT - 1; i++)
                bytes_next[i] = bytes_reg[i+1];
            bytes_next[wtpe_pkg::MAX_OUT-1] = '0;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (item_take)
                in_valid_reg <= 1'b1;
            else if (move)
                in_valid_reg <= 1'b0;

            if (move)
                st_reg <= st_next;

            cnt_reg <= cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
            in_item_reg <= item_data;
        bytes_reg <= bytes_next;
        if (move)
        begin
            has_reg  <= bundle.has_byte;
            last_reg <= bundle.last;
        end
    end

endmodule

`default_nettype wire
